[design/tlbpt_pkg.sv]
// Shared constants, types and command structs for the TLB page translation unit.
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W  = 16;
    localparam int TOTAL_W = 32;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = $clog2(TLB_ENTRIES);
    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Victim search token, passed from cell to cell.
    typedef struct packed {
        logic   active;
        logic   found_empty;
        logic   seeded;
        idx_t   idx;
        count_t cnt;
    } tok_t;

    // Broadcast command from the controller to all cells.
    typedef struct packed {
        logic   inc;
        logic   install;
        idx_t   idx;
        page_t  page;
        frame_t frame;
    } cell_cmd_t;

endpackage

[design/tlb_page_translation_unit.sv]
// Top level: TLB lookup control, page fault handling, totals and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | s_logical_address
//  m_      | out       | m_valid / m_ready  | m_physical_address, m_tlb_hit,
//          |           |                    | m_page_fault, m_hit_total, m_fault_total
//
// One address at a time. A TLB hit goes through accept and lookup.
// A miss goes on through scan and install: the victim token walks the cell chain one slot a cycle.
// Page table reads are registered, issued at the accept edge.
// s_ready is high only when no address is in flight; a held result does not block acceptance.
// Synchronous active-low reset clears valid bits, totals and the frame counter.
module tlb_page_translation_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlbpt_pkg::ADDR_W-1:0]  s_logical_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlbpt_pkg::ADDR_W-1:0]  m_physical_address,
    output logic                          m_tlb_hit,
    output logic                          m_page_fault,
    output logic [tlbpt_pkg::TOTAL_W-1:0] m_hit_total,
    output logic [tlbpt_pkg::TOTAL_W-1:0] m_fault_total
);
    import tlbpt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_LOOKUP  = 4'b0010,
        ST_SCAN    = 4'b0100,
        ST_INSTALL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    page_t                    page_reg;
    logic [OFFSET_BITS-1:0]   offset_reg;
    frame_t                   frame_reg;
    logic                     fault_reg;
    idx_t                     victim_reg;
    frame_t                   next_frame_reg;
    logic [TOTAL_W-1:0]       hits_reg, hits_next;
    logic [TOTAL_W-1:0]       faults_reg, faults_next;
    tok_t                     tok_start_reg;

    logic                     m_valid_reg;
    logic [ADDR_W-1:0]        phys_reg;
    logic                     hit_out_reg;
    logic                     fault_out_reg;
    logic [TOTAL_W-1:0]       hit_total_reg;
    logic [TOTAL_W-1:0]       fault_total_reg;

    page_t                    s_page;
    logic [TLB_ENTRIES-1:0]   match_vec;
    frame_t                   cell_frame [TLB_ENTRIES];
    tok_t                     tok_chain  [TLB_ENTRIES+1];
    tok_t                     tok_last;
    cell_cmd_t                cmd;
    logic                     hit_any;
    idx_t                     hit_idx;
    frame_t                   hit_frame;
    logic                     pt_valid;
    frame_t                   pt_frame;
    logic                     pt_wr;
    logic                     out_free;
    logic                     load_hit;
    logic                     load_inst;
    logic                     miss_go;

    assign s_page  = PAGE_W'((s_logical_address >> OFFSET_BITS) % PAGE_COUNT);
    assign s_ready = (state_reg == ST_IDLE);

    tlbpt_pgtable u_pgtable (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_valid && s_ready),
        .rd_page  (s_page),
        .rd_valid (pt_valid),
        .rd_frame (pt_frame),
        .wr_en    (pt_wr),
        .wr_page  (page_reg),
        .wr_frame (next_frame_reg)
    );

    assign tok_chain[0] = tok_start_reg;
    assign tok_last     = tok_chain[TLB_ENTRIES];

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        tlbpt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(g)),
            .lookup_page (page_reg),
            .cmd         (cmd),
            .tok_in      (tok_chain[g]),
            .tok_out     (tok_chain[g+1]),
            .match       (match_vec[g]),
            .frame       (cell_frame[g])
        );
    end

    // Lowest-indexed matching slot wins.
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end
    assign hit_frame = cell_frame[hit_idx];

    assign out_free  = !m_valid_reg || m_ready;
    assign load_hit  = (state_reg == ST_LOOKUP) && hit_any && out_free;
    assign miss_go   = (state_reg == ST_LOOKUP) && !hit_any;
    assign load_inst = (state_reg == ST_INSTALL) && out_free;
    assign pt_wr     = miss_go && !pt_valid;

    assign hits_next   = (hits_reg == TOTAL_MAX) ? hits_reg : hits_reg + 1'b1;
    assign faults_next = (faults_reg == TOTAL_MAX) ? faults_reg : faults_reg + 1'b1;

    always_comb begin
        cmd.inc     = load_hit;
        cmd.install = load_inst;
        cmd.idx     = load_hit ? hit_idx : victim_reg;
        cmd.page    = page_reg;
        cmd.frame   = frame_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!hit_any) begin
                    state_next = ST_SCAN;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (tok_last.active) begin
                    state_next = ST_INSTALL;
                end
            end
            ST_INSTALL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_frame_reg <= '0;
            hits_reg       <= '0;
            faults_reg     <= '0;
            tok_start_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            tok_start_reg <= '{active: miss_go, found_empty: 1'b0, seeded: 1'b0,
                               idx: '0, cnt: '0};
            if (load_hit) begin
                hits_reg <= hits_next;
            end
            if (pt_wr) begin
                faults_reg     <= faults_next;
                next_frame_reg <= (next_frame_reg == FRAME_LAST) ? '0
                                                                 : next_frame_reg + 1'b1;
            end
            if (load_hit || load_inst) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            page_reg   <= s_page;
            offset_reg <= s_logical_address[OFFSET_BITS-1:0];
        end
        if (miss_go) begin
            frame_reg <= pt_valid ? pt_frame : next_frame_reg;
            fault_reg <= !pt_valid;
        end
        if (state_reg == ST_SCAN && tok_last.active) begin
            victim_reg <= tok_last.idx;
        end
        if (load_hit) begin
            phys_reg        <= ADDR_W'(({(ADDR_W + FRAME_W)'(0)} | hit_frame) << OFFSET_BITS
                                       | offset_reg);
            hit_out_reg     <= 1'b1;
            fault_out_reg   <= 1'b0;
            hit_total_reg   <= hits_next;
            fault_total_reg <= faults_reg;
        end else if (load_inst) begin
            phys_reg        <= ADDR_W'(({(ADDR_W + FRAME_W)'(0)} | frame_reg) << OFFSET_BITS
                                       | offset_reg);
            hit_out_reg     <= 1'b0;
            fault_out_reg   <= fault_reg;
            hit_total_reg   <= hits_reg;
            fault_total_reg <= faults_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_physical_address = phys_reg;
    assign m_tlb_hit          = hit_out_reg;
    assign m_page_fault       = fault_out_reg;
    assign m_hit_total        = hit_total_reg;
    assign m_fault_total      = fault_total_reg;

    a_hit_fault_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tlb_hit && m_page_fault))
        else $error("hit and fault both set on a result");

    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOOKUP))
        else $error("accepted address did not enter lookup");

    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.active |-> (state_reg == ST_SCAN))
        else $error("victim token left the chain outside the scan");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && tok_last.active) |=> (state_reg == ST_INSTALL))
        else $error("scan result not followed by install");

    a_hits_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (hits_reg >= $past(hits_reg)))
        else $error("hit total decreased");

endmodule

[design/tlbpt_cell.sv]
// One TLB slot: entry storage, page compare and one stage of the victim search chain.
module tlbpt_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  tlbpt_pkg::idx_t     cell_idx,
    input  tlbpt_pkg::page_t    lookup_page,
    input  tlbpt_pkg::cell_cmd_t cmd,
    input  tlbpt_pkg::tok_t     tok_in,
    output tlbpt_pkg::tok_t     tok_out,
    output logic                match,
    output tlbpt_pkg::frame_t   frame
);
    import tlbpt_pkg::*;

    logic   valid_reg;
    page_t  page_reg;
    frame_t frame_reg;
    count_t cnt_reg;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   sel;

    assign sel     = (cmd.idx == cell_idx);
    assign match   = valid_reg && (page_reg == lookup_page);
    assign frame   = frame_reg;
    assign tok_out = tok_reg;

    // Lowest empty slot wins; otherwise keep the first strictly smaller count.
    always_comb begin
        tok_next = tok_in;
        if (!tok_in.found_empty) begin
            if (!valid_reg) begin
                tok_next.found_empty = 1'b1;
                tok_next.idx         = cell_idx;
            end else if (!tok_in.seeded || (cnt_reg < tok_in.cnt)) begin
                tok_next.seeded = 1'b1;
                tok_next.idx    = cell_idx;
                tok_next.cnt    = cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg.active <= tok_in.active;
            if (cmd.install && sel) begin
                valid_reg <= 1'b1;
            end
        end
        tok_reg.found_empty <= tok_next.found_empty;
        tok_reg.seeded      <= tok_next.seeded;
        tok_reg.idx         <= tok_next.idx;
        tok_reg.cnt         <= tok_next.cnt;
        if (cmd.install && sel) begin
            page_reg  <= cmd.page;
            frame_reg <= cmd.frame;
            cnt_reg   <= '0;
        end else if (cmd.inc && sel && (cnt_reg != COUNT_MAX)) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

[design/tlbpt_pgtable.sv]
// Page table: frame memory with registered read and per-page valid flops.
module tlbpt_pgtable (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  tlbpt_pkg::page_t  rd_page,
    output logic              rd_valid,
    output tlbpt_pkg::frame_t rd_frame,
    input  logic              wr_en,
    input  tlbpt_pkg::page_t  wr_page,
    input  tlbpt_pkg::frame_t wr_frame
);
    import tlbpt_pkg::*;

    frame_t                frame_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;
    frame_t                rd_frame_reg;

    assign rd_valid = rd_valid_reg;
    assign rd_frame = rd_frame_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_page] <= wr_frame;
        end
        if (rd_en) begin
            rd_frame_reg <= frame_mem[rd_page];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_page] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_page];
            end
        end
    end

endmodule

[sim/tlb_page_translation_unit_tb.sv]
// Testbench for the TLB page translation unit: directed and random address streams.
`timescale 1ns / 1ps

module tlb_page_translation_unit_tb;
    import tlbpt_pkg::*;

    localparam int REPORT_LIMIT = 40;
    localparam int WORKING_SET  = 24;
    localparam int TAIL_CYCLES  = TLB_ENTRIES + 8;

    typedef struct {
        logic [ADDR_W-1:0]  phys;
        logic               hit;
        logic               fault;
        logic [TOTAL_W-1:0] hits;
        logic [TOTAL_W-1:0] faults;
    } xlate_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ADDR_W-1:0]   s_logical_address;
    logic                m_valid;
    logic                m_ready;
    logic [ADDR_W-1:0]   m_physical_address;
    logic                m_tlb_hit;
    logic                m_page_fault;
    logic [TOTAL_W-1:0]  m_hit_total;
    logic [TOTAL_W-1:0]  m_fault_total;

    // Shadow copy of the page table and TLB
    logic               pte_valid [PAGE_COUNT];
    frame_t             pte_frame [PAGE_COUNT];
    logic               slot_valid [TLB_ENTRIES];
    page_t              slot_page [TLB_ENTRIES];
    frame_t             slot_frame [TLB_ENTRIES];
    count_t             slot_uses [TLB_ENTRIES];
    frame_t             frame_counter;
    logic [TOTAL_W-1:0] hit_count;
    logic [TOTAL_W-1:0] fault_count;

    xlate_t pending_translations[$];

    int  error_count;
    int  translations_seen;
    int  hits_seen;
    int  faults_seen;
    int  rx_stall;
    bit  tx_no_idle;
    bit  rx_no_idle;

    tlb_page_translation_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_logical_address  (s_logical_address),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_physical_address (m_physical_address),
        .m_tlb_hit          (m_tlb_hit),
        .m_page_fault       (m_page_fault),
        .m_hit_total        (m_hit_total),
        .m_fault_total      (m_fault_total)
    );

    always #4 aclk = ~aclk;

    function automatic xlate_t translate_address(input logic [ADDR_W-1:0] laddr);
        page_t                  pg;
        frame_t                 fr;
        logic [OFFSET_BITS-1:0] ofs;
        logic                   hit;
        logic                   fault;
        int                     victim;
        xlate_t                 r;
        pg    = page_t'(laddr >> OFFSET_BITS);
        ofs   = laddr[OFFSET_BITS-1:0];
        fr    = '0;
        hit   = 1'b0;
        fault = 1'b0;
        // lowest matching slot wins
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && slot_valid[i] && slot_page[i] == pg) begin
                fr  = slot_frame[i];
                hit = 1'b1;
                if (slot_uses[i] != COUNT_MAX) slot_uses[i]++;
                if (hit_count != TOTAL_MAX) hit_count++;
            end
        end
        if (!hit) begin
            if (pte_valid[pg]) begin
                fr = pte_frame[pg];
            end else begin
                fault = 1'b1;
                if (fault_count != TOTAL_MAX) fault_count++;
                fr = frame_counter;
                pte_frame[pg] = fr;
                pte_valid[pg] = 1'b1;
                frame_counter = (frame_counter == FRAME_LAST) ? '0 : frame_counter + 1'b1;
            end
            // lowest empty slot, else least used (ties go to the lowest index)
            victim = -1;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                if (victim < 0 && !slot_valid[i]) victim = i;
            end
            if (victim < 0) begin
                victim = 0;
                for (int i = 1; i < TLB_ENTRIES; i++) begin
                    if (slot_uses[i] < slot_uses[victim]) victim = i;
                end
            end
            slot_valid[victim] = 1'b1;
            slot_page[victim]  = pg;
            slot_frame[victim] = fr;
            slot_uses[victim]  = '0;
        end
        r.phys   = ADDR_W'((32'(fr) << OFFSET_BITS) | 32'(ofs));
        r.hit    = hit;
        r.fault  = fault;
        r.hits   = hit_count;
        r.faults = fault_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            error_count++;
            // past the limit mismatches are only counted
            if (error_count <= REPORT_LIMIT)
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Result checker; also draws the stall before the next result transfer
    always @(posedge aclk) begin
        xlate_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_translations.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $error("unexpected result: physical_address %0h", m_physical_address);
            end else begin
                want = pending_translations.pop_front();
                check_field("physical_address", TOTAL_W'(want.phys), TOTAL_W'(m_physical_address));
                check_field("tlb_hit", TOTAL_W'(want.hit), TOTAL_W'(m_tlb_hit));
                check_field("page_fault", TOTAL_W'(want.fault), TOTAL_W'(m_page_fault));
                check_field("hit_total", want.hits, m_hit_total);
                check_field("fault_total", want.faults, m_fault_total);
                translations_seen++;
                if (want.hit) hits_seen++;
                if (want.fault) faults_seen++;
            end
            rx_stall = rx_no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Called and returns just after a falling edge
    task automatic send_address(input logic [ADDR_W-1:0] laddr);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_logical_address <= laddr;
        do @(posedge aclk); while (!s_ready);
        pending_translations.push_back(translate_address(laddr));
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_translations.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_address_extremes();
        send_address(16'h0000);
        send_address(16'hFFFF);
        send_address(16'h00FF);
        send_address(16'hFF00);
        send_address(16'h55AA);
        send_address(16'hAA55);
        wait_for_results();
    endtask

    // Fill the TLB, then force least-used evictions and page table reuse
    task automatic test_lfu_replacement();
        for (int p = 1; p < TLB_ENTRIES; p++)
            send_address({page_t'(p), OFFSET_BITS'($urandom)});
        send_address({page_t'(8'h30), OFFSET_BITS'($urandom)});
        send_address({page_t'(8'h01), OFFSET_BITS'($urandom)});
        send_address({page_t'(8'h02), OFFSET_BITS'($urandom)});
        wait_for_results();
    endtask

    // Drifting working set larger than the TLB, plus scattered pages
    task automatic test_random_traffic(input int count);
        page_t working[WORKING_SET];
        page_t pg;
        int    pick;
        int    slot;
        foreach (working[k]) working[k] = page_t'($urandom_range(0, PAGE_COUNT - 1));
        for (int n = 0; n < count; n++) begin
            if (n % 125 == 0) begin
                tx_no_idle = ($urandom_range(0, 3) == 0);
                rx_no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == count / 2) wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                pg = page_t'($urandom_range(0, PAGE_COUNT - 1));
            end else begin
                slot = $urandom_range(0, WORKING_SET - 1);
                if (pick < 20) working[slot] = page_t'($urandom_range(0, PAGE_COUNT - 1));
                pg = working[slot];
            end
            send_address({pg, OFFSET_BITS'($urandom)});
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        wait_for_results();
    endtask

    // Touch every page so the frame counter wraps, then revisit a few
    task automatic test_page_sweep();
        for (int p = 0; p < PAGE_COUNT; p++)
            send_address({page_t'(p), OFFSET_BITS'($urandom)});
        repeat (8) send_address(ADDR_W'($urandom));
        wait_for_results();
    endtask

    initial begin
        int waited;
        aclk              = 1'b0;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_logical_address = '0;
        m_ready           = 1'b0;
        rx_stall          = 0;
        tx_no_idle        = 1'b0;
        rx_no_idle        = 1'b0;
        error_count       = 0;
        translations_seen = 0;
        hits_seen         = 0;
        faults_seen       = 0;
        frame_counter     = '0;
        hit_count         = '0;
        fault_count       = '0;
        foreach (pte_valid[p]) begin
            pte_valid[p] = 1'b0;
            pte_frame[p] = '0;
        end
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_page[i]  = '0;
            slot_frame[i] = '0;
            slot_uses[i]  = '0;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_address_extremes();
        test_lfu_replacement();
        test_random_traffic(1462);
        test_page_sweep();

        s_valid <= 1'b0;
        waited = 0;
        while (pending_translations.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_translations.size() != 0) begin
            error_count++;
            $error("%0d translations never returned", pending_translations.size());
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d translations: %0d TLB hits, %0d page faults.",
                 translations_seen, hits_seen, faults_seen);
        $display("Covered LFU eviction, page table reuse, frame wrap and random stalls.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
design/tlbpt_pkg.sv
design/tlbpt_cell.sv
design/tlbpt_pgtable.sv
design/tlb_page_translation_unit.sv
sim/tlb_page_translation_unit_tb.sv
